FILE: hdl/sfd_pkg.sv
// Shared types and constants for the spatiotemporal flag denoiser.
// Used by the front end, the back end and the top level; depends on nothing.
`default_nettype none

package sfd_pkg;

   // Field and register widths.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int COLS_W      = 8;
   localparam int ROWS_W      = 7;
   localparam int THR_W       = 4;
   localparam int OUT_COL_W   = 7;
   localparam int OUT_ROW_W   = 6;

   // Four flag planes: the one being filled and the last three whole frames.
   localparam int PLANES      = 4;
   localparam int PLANE_W     = 2;

   // Rows are spread over three memory banks by row number modulo three.
   localparam int BANKS       = 3;

   localparam int QUEUE_DEPTH = 4;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_COLS       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ROWS       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_THRESHOLD = 2'd2;

   // Register values after reset.
   localparam logic [COLS_W-1:0] COLS_RESET = 8'd80;
   localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd54;
   localparam logic [THR_W-1:0]  THR_RESET  = 4'd2;

   // Classification of one request, passed from the front end to the back end.
   typedef struct packed {
      logic               flag;
      logic               valid_frame;
      logic               full_history;
      logic               interior;
      logic               last;
      logic [PLANE_W-1:0] newest;
      logic [1:0]         bank;
   } cell_ctl_type;

   // Settings the back end takes from the register file.
   typedef struct packed {
      logic [THR_W-1:0] threshold;
      logic             restart;
   } back_cfg_type;

endpackage

`default_nettype wire

FILE: hdl/sfd_front.sv
// Front end: register file, raster position tracking and request classification.
// Depends on sfd_pkg.
`default_nettype none

module sfd_front #(
   parameter int  MAX_COLS  = 128,
   parameter int  MAX_ROWS  = 64,
   localparam int CW        = $clog2(MAX_COLS),
   localparam int RW        = $clog2(MAX_ROWS),
   localparam int BANK_ROWS = (MAX_ROWS + 2) / 3,
   localparam int QW        = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [sfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sfd_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic                             req_valid,
   input  wire logic                             req_cell_flag,
   input  wire logic                             hold,
   output logic                                  push,
   output sfd_pkg::cell_ctl_type                 push_ctl,
   output logic [RW-1:0]                         push_row,
   output logic [CW-1:0]                         push_col,
   output logic [QW-1:0]                         push_bq,
   output sfd_pkg::back_cfg_type                 back_cfg
);
   import sfd_pkg::*;

   localparam int CCW = CW + 1;
   localparam int CRW = RW + 1;
   localparam logic [1:0]         LAST_BANK = 2'(BANKS - 1);
   localparam logic [PLANE_W-1:0] SEEN_FULL = 2'd3;

   function automatic logic [CCW-1:0] clamp_cols(input logic [COLS_W-1:0] v);
      logic [CCW-1:0] res;
      if (v < COLS_W'(3)) begin
         res = CCW'(3);
      end else if (32'(v) > MAX_COLS) begin
         res = CCW'(MAX_COLS);
      end else begin
         res = CCW'(v);
      end
      return res;
   endfunction

   function automatic logic [CRW-1:0] clamp_rows(input logic [ROWS_W-1:0] v);
      logic [CRW-1:0] res;
      if (v < ROWS_W'(3)) begin
         res = CRW'(3);
      end else if (32'(v) > MAX_ROWS) begin
         res = CRW'(MAX_ROWS);
      end else begin
         res = CRW'(v);
      end
      return res;
   endfunction

   logic [CCW-1:0]     cols_ff, cols_in;
   logic [CRW-1:0]     rows_ff, rows_in;
   logic [THR_W-1:0]   thr_ff, thr_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [QW-1:0]      bq_ff, bq_in;
   logic [1:0]         bm_ff, bm_in;
   logic [PLANE_W-1:0] newest_ff, newest_in;
   logic [PLANE_W-1:0] seen_ff, seen_in;

   logic csr_wr;
   logic geo_wr;
   logic last_col;
   logic last_row;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign geo_wr    = csr_wr && (csr_index == CSR_GRID_COLS || csr_index == CSR_GRID_ROWS);

   assign push     = req_valid && !hold;
   assign last_col = (CCW'(col_ff) + CCW'(1)) == cols_ff;
   assign last_row = (CRW'(row_ff) + CRW'(1)) == rows_ff;

   always_comb begin
      cols_in   = cols_ff;
      rows_in   = rows_ff;
      thr_in    = thr_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      bq_in     = bq_ff;
      bm_in     = bm_ff;
      newest_in = newest_ff;
      seen_in   = seen_ff;

      if (push) begin
         if (last_col && last_row) begin
            col_in    = '0;
            row_in    = '0;
            bq_in     = '0;
            bm_in     = '0;
            newest_in = newest_ff + PLANE_W'(1);
            if (seen_ff != SEEN_FULL) begin
               seen_in = seen_ff + PLANE_W'(1);
            end
         end else if (last_col) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
            if (bm_ff == LAST_BANK) begin
               bm_in = '0;
               bq_in = bq_ff + QW'(1);
            end else begin
               bm_in = bm_ff + 2'd1;
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end

      // A geometry write starts the frame over at the top left.
      if (geo_wr) begin
         col_in = '0;
         row_in = '0;
         bq_in  = '0;
         bm_in  = '0;
      end

      if (csr_wr) begin
         if (csr_index == CSR_GRID_COLS) begin
            cols_in = clamp_cols(csr_data[COLS_W-1:0]);
         end else if (csr_index == CSR_GRID_ROWS) begin
            rows_in = clamp_rows(csr_data[ROWS_W-1:0]);
         end else if (csr_index == CSR_COUNT_THRESHOLD) begin
            thr_in = csr_data[THR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff   <= clamp_cols(COLS_RESET);
         rows_ff   <= clamp_rows(ROWS_RESET);
         thr_ff    <= THR_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         bq_ff     <= '0;
         bm_ff     <= '0;
         newest_ff <= '0;
         seen_ff   <= '0;
      end else begin
         cols_ff   <= cols_in;
         rows_ff   <= rows_in;
         thr_ff    <= thr_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         bq_ff     <= bq_in;
         bm_ff     <= bm_in;
         newest_ff <= newest_in;
         seen_ff   <= seen_in;
      end
   end

   always_comb begin
      push_ctl.flag         = req_cell_flag;
      push_ctl.valid_frame  = seen_ff[1];
      push_ctl.full_history = (seen_ff == SEEN_FULL);
      push_ctl.interior     = (row_ff != '0) && !last_row && (col_ff != '0) && !last_col;
      push_ctl.last         = last_col && last_row;
      push_ctl.newest       = newest_ff;
      push_ctl.bank         = bm_ff;
   end

   assign push_row = row_ff;
   assign push_col = col_ff;
   assign push_bq  = bq_ff;

   assign back_cfg.threshold = thr_ff;
   assign back_cfg.restart   = geo_wr;

endmodule

`default_nettype wire

FILE: hdl/sfd_queue.sv
// Short first-in first-out queue between the front end and the back end.
// Generic in width and depth; depends on nothing.
`default_nettype none

module sfd_queue #(
   parameter int  DW    = 32,
   parameter int  DEPTH = 4,
   localparam int PW    = $clog2(DEPTH),
   localparam int NW    = $clog2(DEPTH + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire logic [DW-1:0] push_data,
   output logic               full,
   input  wire logic          pop,
   output logic               pop_valid,
   output logic [DW-1:0]      pop_data
);

   logic [DW-1:0] entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] fill_ff, fill_in;

   assign full      = (fill_ff == NW'(DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + NW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/sfd_back.sv
// Back end: banked flag plane memory, 3x3x3 window counting and the result register.
// Depends on sfd_pkg.
`default_nettype none

module sfd_back #(
   parameter int  MAX_COLS  = 128,
   parameter int  MAX_ROWS  = 64,
   localparam int CW        = $clog2(MAX_COLS),
   localparam int RW        = $clog2(MAX_ROWS),
   localparam int BANK_ROWS = (MAX_ROWS + 2) / 3,
   localparam int QW        = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  sfd_pkg::back_cfg_type                back_cfg,
   input  wire logic                            pop_valid,
   input  sfd_pkg::cell_ctl_type                pop_ctl,
   input  wire logic [RW-1:0]                   pop_row,
   input  wire logic [CW-1:0]                   pop_col,
   input  wire logic [QW-1:0]                   pop_bq,
   output logic                                 pop,
   output logic                                 clearing,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_valid,
   output logic                                 rsp_filtered_flag,
   output logic [sfd_pkg::OUT_COL_W-1:0]        rsp_out_col,
   output logic [sfd_pkg::OUT_ROW_W-1:0]        rsp_out_row,
   output logic                                 rsp_out_valid_frame,
   output logic                                 rsp_frame_has_anomaly,
   output logic                                 rsp_last_of_frame
);
   import sfd_pkg::*;

   localparam int ROW_UP  = 0;
   localparam int ROW_MID = 1;
   localparam int ROW_DN  = 2;

   // One window column: rows above, at and below the cell, each with all planes.
   typedef logic [2:0][PLANES-1:0] column_type;

   function automatic logic [3:0] count_plane(input column_type lc, input column_type cc,
                                              input column_type rc,
                                              input logic [PLANE_W-1:0] p);
      logic [3:0] s;
      s = '0;
      for (int k = 0; k < 3; k++) begin
         s = s + 4'(lc[k][p]) + 4'(cc[k][p]) + 4'(rc[k][p]);
      end
      return s;
   endfunction

   // Clearing sweep.
   logic          clr_ff, clr_in;
   logic [QW-1:0] clr_q_ff, clr_q_in;
   logic [CW-1:0] clr_c_ff, clr_c_in;

   // Read stage.
   logic               s1_v_ff, s1_v_in;
   cell_ctl_type       s1_ctl_ff;
   logic [RW-1:0]      s1_row_ff;
   logic [CW-1:0]      s1_col_ff;
   logic [PLANES-1:0]  rd_a_ff [BANKS];
   logic [PLANES-1:0]  rd_b_ff [BANKS];
   column_type         left_ff;

   // Result stage.
   logic                  out_v_ff, out_v_in;
   logic                  any_ff, any_in;
   logic                  out_flag_ff;
   logic [OUT_COL_W-1:0]  out_col_ff;
   logic [OUT_ROW_W-1:0]  out_row_ff;
   logic                  out_vf_ff;
   logic                  out_has_ff;
   logic                  out_last_ff;

   logic               out_free;
   logic               s1_move;
   logic               s1_load_ok;
   logic [CW-1:0]      col_nx;
   column_type         col_c;
   column_type         col_r;
   logic [PLANE_W-1:0] p_prev, p_emit, p_next;
   logic [3:0]         cnt_prev, cnt_emit, cnt_next;
   logic               filt;
   logic               has;

   assign clearing   = clr_ff;
   assign out_free   = !out_v_ff || !rsp_stall;
   assign s1_move    = s1_v_ff && out_free;
   assign s1_load_ok = !s1_v_ff || out_free;
   assign pop        = pop_valid && s1_load_ok && !clr_ff;
   assign col_nx     = pop_col + CW'(1);

   always_comb begin
      clr_in   = clr_ff;
      clr_q_in = clr_q_ff;
      clr_c_in = clr_c_ff;
      if (clr_ff) begin
         if (clr_c_ff == CW'(MAX_COLS - 1)) begin
            clr_c_in = '0;
            if (clr_q_ff == QW'(BANK_ROWS - 1)) begin
               clr_in = 1'b0;
            end else begin
               clr_q_in = clr_q_ff + QW'(1);
            end
         end else begin
            clr_c_in = clr_c_ff + CW'(1);
         end
      end
   end

   // Each bank holds rows of one residue modulo three, four plane bits per word.
   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      localparam logic [1:0] BK     = 2'(b);
      localparam logic [1:0] BK_NXT = 2'((b + 1) % BANKS);

      logic [PLANES-1:0] mem [BANK_ROWS][MAX_COLS];
      logic [QW-1:0]     raddr;

      // The bank serves the cell's own row, the row above or the row below.
      always_comb begin
         if (pop_ctl.bank == BK) begin
            raddr = pop_bq;
         end else if (pop_ctl.bank == BK_NXT) begin
            raddr = (b == BANKS - 1) ? pop_bq - QW'(1) : pop_bq;
         end else begin
            raddr = (b == 0) ? pop_bq + QW'(1) : pop_bq;
         end
      end

      always_ff @(posedge clock) begin
         if (clr_ff) begin
            mem[clr_q_ff][clr_c_ff] <= '0;
         end else if (pop && pop_ctl.bank == BK) begin
            mem[pop_bq][pop_col][pop_ctl.newest] <= pop_ctl.flag;
         end
         if (pop) begin
            rd_a_ff[b] <= mem[raddr][col_nx];
            rd_b_ff[b] <= mem[raddr][pop_col];
         end
      end
   end

   // Put the bank outputs back into row order.
   always_comb begin
      unique case (s1_ctl_ff.bank)
         2'd1: begin
            col_c[ROW_UP] = rd_b_ff[0]; col_c[ROW_MID] = rd_b_ff[1]; col_c[ROW_DN] = rd_b_ff[2];
            col_r[ROW_UP] = rd_a_ff[0]; col_r[ROW_MID] = rd_a_ff[1]; col_r[ROW_DN] = rd_a_ff[2];
         end
         2'd2: begin
            col_c[ROW_UP] = rd_b_ff[1]; col_c[ROW_MID] = rd_b_ff[2]; col_c[ROW_DN] = rd_b_ff[0];
            col_r[ROW_UP] = rd_a_ff[1]; col_r[ROW_MID] = rd_a_ff[2]; col_r[ROW_DN] = rd_a_ff[0];
         end
         default: begin
            col_c[ROW_UP] = rd_b_ff[2]; col_c[ROW_MID] = rd_b_ff[0]; col_c[ROW_DN] = rd_b_ff[1];
            col_r[ROW_UP] = rd_a_ff[2]; col_r[ROW_MID] = rd_a_ff[0]; col_r[ROW_DN] = rd_a_ff[1];
         end
      endcase
   end

   assign p_prev = s1_ctl_ff.newest + PLANE_W'(1);
   assign p_emit = s1_ctl_ff.newest + PLANE_W'(2);
   assign p_next = s1_ctl_ff.newest + PLANE_W'(3);

   assign cnt_prev = count_plane(left_ff, col_c, col_r, p_prev);
   assign cnt_emit = count_plane(left_ff, col_c, col_r, p_emit);
   assign cnt_next = count_plane(left_ff, col_c, col_r, p_next);

   always_comb begin
      filt = s1_ctl_ff.valid_frame && col_c[ROW_MID][p_emit];
      if (s1_ctl_ff.full_history && s1_ctl_ff.interior &&
          cnt_prev < back_cfg.threshold && cnt_emit < back_cfg.threshold &&
          cnt_next < back_cfg.threshold) begin
         filt = 1'b0;
      end
      has = s1_ctl_ff.last && s1_ctl_ff.valid_frame && (any_ff || filt);
   end

   always_comb begin
      s1_v_in = s1_v_ff;
      if (s1_load_ok) begin
         s1_v_in = pop;
      end
      out_v_in = out_v_ff;
      if (out_free) begin
         out_v_in = s1_v_ff;
      end
      any_in = any_ff;
      if (back_cfg.restart) begin
         any_in = 1'b0;
      end else if (s1_move) begin
         any_in = s1_ctl_ff.last ? 1'b0 : (any_ff || filt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= 1'b1;
         clr_q_ff <= '0;
         clr_c_ff <= '0;
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         any_ff   <= 1'b0;
      end else begin
         clr_ff   <= clr_in;
         clr_q_ff <= clr_q_in;
         clr_c_ff <= clr_c_in;
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
         any_ff   <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ctl_ff <= pop_ctl;
         s1_row_ff <= pop_row;
         s1_col_ff <= pop_col;
      end
      if (s1_move) begin
         left_ff     <= col_c;
         out_flag_ff <= filt;
         out_col_ff  <= OUT_COL_W'(s1_col_ff);
         out_row_ff  <= OUT_ROW_W'(s1_row_ff);
         out_vf_ff   <= s1_ctl_ff.valid_frame;
         out_has_ff  <= has;
         out_last_ff <= s1_ctl_ff.last;
      end
   end

   assign rsp_valid             = out_v_ff;
   assign rsp_filtered_flag     = out_flag_ff;
   assign rsp_out_col           = out_col_ff;
   assign rsp_out_row           = out_row_ff;
   assign rsp_out_valid_frame   = out_vf_ff;
   assign rsp_frame_has_anomaly = out_has_ff;
   assign rsp_last_of_frame     = out_last_ff;

endmodule

`default_nettype wire

FILE: hdl/spatiotemporal_flag_denoise.sv
// Top level of the spatiotemporal 3x3x3 neighbour-count flag denoiser.
// Depends on sfd_pkg, sfd_front, sfd_queue and sfd_back.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   req_cell_flag
//   rsp_      out        rsp_valid/rsp_stall   filtered flag, position, frame status
//   csr_      in         csr_valid/csr_ready   csr_index, csr_data
//
// One request is accepted per clock cycle when nothing stalls, and each request yields
// exactly one response, passing in turn through the queue, the banked plane memory
// read, and the 3x3x3 count with the result register. After reset the plane memory is
// swept to zero, one word per bank per cycle, with req_stall held high; register writes
// are taken throughout. req_stall otherwise rises only when the four-entry queue is
// full, so a stalled response does not stall the input until then.
`default_nettype none

module spatiotemporal_flag_denoise #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [sfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sfd_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_cell_flag,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_filtered_flag,
   output logic [sfd_pkg::OUT_COL_W-1:0]         rsp_out_col,
   output logic [sfd_pkg::OUT_ROW_W-1:0]         rsp_out_row,
   output logic                                  rsp_out_valid_frame,
   output logic                                  rsp_frame_has_anomaly,
   output logic                                  rsp_last_of_frame
);
   import sfd_pkg::*;

   localparam int CW        = $clog2(MAX_COLS);
   localparam int RW        = $clog2(MAX_ROWS);
   localparam int BANK_ROWS = (MAX_ROWS + 2) / 3;
   localparam int QW        = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;
   localparam int CTL_W     = $bits(cell_ctl_type);
   localparam int DW        = CTL_W + RW + CW + QW;

   // Front end to queue.
   logic          f_push;
   cell_ctl_type  f_ctl;
   logic [RW-1:0] f_row;
   logic [CW-1:0] f_col;
   logic [QW-1:0] f_bq;
   back_cfg_type  back_cfg;

   // Queue to back end.
   logic [DW-1:0] q_push_data;
   logic [DW-1:0] q_pop_data;
   logic          q_full;
   logic          q_pop_valid;
   logic          b_pop;
   cell_ctl_type  b_ctl;
   logic [RW-1:0] b_row;
   logic [CW-1:0] b_col;
   logic [QW-1:0] b_bq;
   logic          clearing;

   // Requests wait while the queue is full or the plane memory is being cleared.
   assign req_stall = q_full || clearing;

   sfd_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_cell_flag (req_cell_flag),
      .hold          (req_stall),
      .push          (f_push),
      .push_ctl      (f_ctl),
      .push_row      (f_row),
      .push_col      (f_col),
      .push_bq       (f_bq),
      .back_cfg      (back_cfg)
   );

   assign q_push_data = {f_ctl, f_row, f_col, f_bq};

   sfd_queue #(
      .DW    (DW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (b_pop),
      .pop_valid (q_pop_valid),
      .pop_data  (q_pop_data)
   );

   assign {b_ctl, b_row, b_col, b_bq} = q_pop_data;

   sfd_back #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .back_cfg              (back_cfg),
      .pop_valid             (q_pop_valid),
      .pop_ctl               (b_ctl),
      .pop_row               (b_row),
      .pop_col               (b_col),
      .pop_bq                (b_bq),
      .pop                   (b_pop),
      .clearing              (clearing),
      .rsp_stall             (rsp_stall),
      .rsp_valid             (rsp_valid),
      .rsp_filtered_flag     (rsp_filtered_flag),
      .rsp_out_col           (rsp_out_col),
      .rsp_out_row           (rsp_out_row),
      .rsp_out_valid_frame   (rsp_out_valid_frame),
      .rsp_frame_has_anomaly (rsp_frame_has_anomaly),
      .rsp_last_of_frame     (rsp_last_of_frame)
   );

   // The frame summary is only ever reported on the closing cell of a frame.
   a_has_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_has_anomaly |-> rsp_last_of_frame)
      else $error("frame anomaly reported away from the last cell");

   // Nothing survives the filter while the delayed frame is still warming up.
   a_warmup_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid_frame |-> !rsp_filtered_flag && !rsp_frame_has_anomaly)
      else $error("flag set during warm-up");

   // While the memory sweep runs, no request can have reached the queue.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_pop_valid && !b_pop)
      else $error("request queued during memory clear");

   // A response that follows the close of a frame starts the next one at the top left.
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_of_frame |=>
         !rsp_valid || (rsp_out_col == '0 && rsp_out_row == '0))
      else $error("frame did not restart at the first cell");

endmodule

`default_nettype wire

FILE: test/spatiotemporal_flag_denoise_test.sv
// Self-checking testbench for the spatiotemporal 3x3x3 flag denoiser.
// Needs sfd_pkg and the spatiotemporal_flag_denoise RTL, nothing else.
// Directed table first, then random register settings and random flag frames.
`default_nettype none

module spatiotemporal_flag_denoise_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sfd_pkg::*;

   // Geometry limits of the instance; the block is built with its default sizes.
   localparam int GRID_MAX_COLS = 128;
   localparam int GRID_MAX_ROWS = 64;

   // Index three is not decoded by the block, so a write to it must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // Margin on top of the shortest path from acceptance to response.
   localparam int SETTLE_CYCLES    = 8;
   localparam int DRAIN_LIMIT      = 20000;
   localparam int HOLD_CYCLES      = 300;
   localparam int RANDOM_REQUESTS  = 2000;
   localparam int PHASE_CAP        = 300;

   // The first few random phases use fixed settings at the edges of every register.
   localparam int EXTREME_SETTINGS = 5;
   localparam int WIDE_PHASE       = 2;
   localparam int TALL_PHASE       = 3;

   typedef struct packed {
      logic                 filtered_flag;
      logic [OUT_COL_W-1:0] out_col;
      logic [OUT_ROW_W-1:0] out_row;
      logic                 out_valid_frame;
      logic                 frame_has_anomaly;
      logic                 last_of_frame;
   } denoised_cell_t;

   // One line of the directed table: either a register write or a flag request.
   typedef struct {
      bit                     is_write;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
      bit                     flag;
      bit                     typed;
      denoised_cell_t         want;
   } stimulus_row_t;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

   // ------------------------------------------------------------------
   // Clock, reset and the block's ports. Every input starts at a known value.
   // ------------------------------------------------------------------
   bit clock;
   logic reset = 1'b1;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_cell_flag = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_filtered_flag;
   logic [OUT_COL_W-1:0]   rsp_out_col;
   logic [OUT_ROW_W-1:0]   rsp_out_row;
   logic                   rsp_out_valid_frame;
   logic                   rsp_frame_has_anomaly;
   logic                   rsp_last_of_frame;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   spatiotemporal_flag_denoise i_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cell_flag        (req_cell_flag),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_filtered_flag    (rsp_filtered_flag),
      .rsp_out_col          (rsp_out_col),
      .rsp_out_row          (rsp_out_row),
      .rsp_out_valid_frame  (rsp_out_valid_frame),
      .rsp_frame_has_anomaly(rsp_frame_has_anomaly),
      .rsp_last_of_frame    (rsp_last_of_frame)
   );

   // ------------------------------------------------------------------
   // Denoiser predictor. It keeps its own four flag planes, frame position
   // and register copies, and works out the response to each request at the
   // moment the block accepts it.
   // ------------------------------------------------------------------
   bit                flag_store [PLANES][GRID_MAX_ROWS][GRID_MAX_COLS];
   int unsigned       next_col;
   int unsigned       next_row;
   logic [PLANE_W-1:0] fill_plane;
   int unsigned       frames_done;
   bit                anomaly_in_frame;
   logic [COLS_W-1:0] cols_reg = COLS_RESET;
   logic [ROWS_W-1:0] rows_reg = ROWS_RESET;
   logic [THR_W-1:0]  threshold_reg = THR_RESET;

   denoised_cell_t expected_cells [$];

   int error_count;
   int request_count;
   int responses_checked;
   int kept_set_count;
   int cleared_count;
   int settings_used;

   // Sender state: bursts of requests separated by idle gaps.
   int burst_left;
   bit gaps_enabled = 1'b1;
   bit hold_wanted  = 1'b0;

   // Out-of-range geometry is clamped to 3..maximum whenever it is used.
   function automatic int grid_width();
      int w;
      w = cols_reg;
      if (w < 3) w = 3;
      if (w > GRID_MAX_COLS) w = GRID_MAX_COLS;
      return w;
   endfunction

   function automatic int grid_height();
      int h;
      h = rows_reg;
      if (h < 3) h = 3;
      if (h > GRID_MAX_ROWS) h = GRID_MAX_ROWS;
      return h;
   endfunction

   // Set flags in the 3x3 neighbourhood of (row, col) in one plane.
   function automatic int window_count(logic [PLANE_W-1:0] plane, int row, int col);
      int total;
      int rr;
      int cc;
      total = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            rr = row + dr;
            cc = col + dc;
            if (rr >= 0 && rr < GRID_MAX_ROWS && cc >= 0 && cc < GRID_MAX_COLS)
               total += flag_store[plane][rr][cc];
         end
      end
      return total;
   endfunction

   // A geometry write restarts the frame position; the planes and the frame
   // count survive it. Unknown indexes fall through untouched.
   function automatic void apply_register_write(logic [CSR_INDEX_W-1:0] index,
                                                logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_GRID_COLS: begin
            cols_reg = value[COLS_W-1:0];
            next_col = 0;
            next_row = 0;
            anomaly_in_frame = 1'b0;
         end
         CSR_GRID_ROWS: begin
            rows_reg = value[ROWS_W-1:0];
            next_col = 0;
            next_row = 0;
            anomaly_in_frame = 1'b0;
         end
         CSR_COUNT_THRESHOLD: threshold_reg = value[THR_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic denoised_cell_t denoise_cell(bit flag);
      denoised_cell_t     res;
      int                 width;
      int                 height;
      int                 row;
      int                 col;
      logic [PLANE_W-1:0] emit_plane;
      logic [PLANE_W-1:0] prior_plane;
      logic [PLANE_W-1:0] later_plane;
      width  = grid_width();
      height = grid_height();
      row    = next_row;
      col    = next_col;
      if (row >= height || col >= width) begin
         row = 0;
         col = 0;
      end
      res = '0;
      flag_store[fill_plane][row][col] = flag;

      // Two frames back is the plane emitted; the one before it and the one
      // after it complete the temporal window.
      if (frames_done >= 2) begin
         emit_plane  = fill_plane + 2'd2;
         prior_plane = fill_plane + 2'd1;
         later_plane = fill_plane + 2'd3;
         res.out_valid_frame = 1'b1;
         res.filtered_flag   = flag_store[emit_plane][row][col];
         if (frames_done >= 3 && res.filtered_flag && row >= 1 && row + 2 <= height &&
             col >= 1 && col + 2 <= width) begin
            if (window_count(prior_plane, row, col) < threshold_reg &&
                window_count(emit_plane, row, col) < threshold_reg &&
                window_count(later_plane, row, col) < threshold_reg) begin
               res.filtered_flag = 1'b0;
               cleared_count++;
            end
         end
         if (res.filtered_flag) kept_set_count++;
      end

      res.last_of_frame = (row + 1 == height) && (col + 1 == width);
      anomaly_in_frame |= res.filtered_flag;
      if (res.last_of_frame) begin
         res.frame_has_anomaly = res.out_valid_frame & anomaly_in_frame;
         anomaly_in_frame = 1'b0;
         next_col   = 0;
         next_row   = 0;
         fill_plane = fill_plane + 2'd1;
         if (frames_done < 3) frames_done++;
      end else if (col + 1 == width) begin
         next_col = 0;
         next_row = row + 1;
      end else begin
         next_col = col + 1;
         next_row = row;
      end
      res.out_col = col[OUT_COL_W-1:0];
      res.out_row = row[OUT_ROW_W-1:0];
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Directed table. The first two frames are warm-up, so every response
   // there is zero apart from its position and last-of-frame mark; the third
   // input frame emits the first frame unchanged. Geometry is written out of
   // range (0 and 2) so the clamp to 3x3 makes these frames nine cells long.
   // ------------------------------------------------------------------
   stimulus_row_t directed_rows [31] = '{
      '{1'b1, CSR_GRID_COLS,       8'd0,   1'b0, 1'b0, '0},
      '{1'b1, CSR_GRID_ROWS,       8'd2,   1'b0, 1'b0, '0},
      '{1'b1, CSR_COUNT_THRESHOLD, 8'd2,   1'b0, 1'b0, '0},
      '{1'b1, CSR_UNUSED,          8'hFF,  1'b0, 1'b0, '0},
      // first frame in: a diagonal
      '{1'b0, '0, '0, 1'b1, 1'b1, '{1'b0, 7'd0, 6'd0, 1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b0, 7'd1, 6'd0, 1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b0, 7'd2, 6'd0, 1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b0, 7'd0, 6'd1, 1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b1, 1'b1, '{1'b0, 7'd1, 6'd1, 1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b0, 7'd2, 6'd1, 1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b0, 7'd0, 6'd2, 1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b0, 7'd1, 6'd2, 1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b1, 1'b1, '{1'b0, 7'd2, 6'd2, 1'b0, 1'b0, 1'b1}},
      // second frame in: a plus sign
      '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b0, 7'd0, 6'd0, 1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b1, 1'b1, '{1'b0, 7'd1, 6'd0, 1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b0, 7'd2, 6'd0, 1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b1, 1'b1, '{1'b0, 7'd0, 6'd1, 1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b1, 1'b1, '{1'b0, 7'd1, 6'd1, 1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b1, 1'b1, '{1'b0, 7'd2, 6'd1, 1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b0, 7'd0, 6'd2, 1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b1, 1'b1, '{1'b0, 7'd1, 6'd2, 1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b0, 7'd2, 6'd2, 1'b0, 1'b0, 1'b1}},
      // third frame in: the diagonal of the first frame comes out untouched
      '{1'b0, '0, '0, 1'b1, 1'b1, '{1'b1, 7'd0, 6'd0, 1'b1, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b1, 1'b1, '{1'b0, 7'd1, 6'd0, 1'b1, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b0, 7'd2, 6'd0, 1'b1, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b0, 7'd0, 6'd1, 1'b1, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b1, 7'd1, 6'd1, 1'b1, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b0, 7'd2, 6'd1, 1'b1, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b0, 7'd0, 6'd2, 1'b1, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b1, 1'b1, '{1'b0, 7'd1, 6'd2, 1'b1, 1'b0, 1'b0}},
      '{1'b0, '0, '0, 1'b1, 1'b1, '{1'b1, 7'd2, 6'd2, 1'b1, 1'b1, 1'b1}}
   };

   // Fixed settings for the first random phases: threshold above nine, threshold
   // zero, the widest grid, the tallest grid, and geometry below the clamp.
   int unsigned extreme_cols [EXTREME_SETTINGS] = '{3, 3, 255, 3, 1};
   int unsigned extreme_rows [EXTREME_SETTINGS] = '{3, 3, 3, 127, 2};
   int unsigned extreme_thr  [EXTREME_SETTINGS] = '{15, 0, 3, 1, 10};

   // ------------------------------------------------------------------
   // Driving tasks. Inputs change on the falling edge; handshakes are
   // judged on the rising edge.
   // ------------------------------------------------------------------
   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      apply_register_write(index, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Offers one request, idling first when the current burst has run out.
   // A typed expectation replaces the predicted one, but the predictor still
   // steps so that its state follows the block.
   task automatic offer_cell(bit flag, bit typed, denoised_cell_t want);
      int gap;
      denoised_cell_t predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = gaps_enabled ? $urandom_range(0, 6) : 0;
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_cell_flag <= flag;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = denoise_cell(flag);
      expected_cells.push_back(typed ? want : predicted);
      request_count++;
   endtask

   // Stops offering and waits for every outstanding response, then waits out
   // the settling margin so the pipeline is truly empty.
   task automatic wait_until_drained();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_cells.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_cells.size() != 0) begin
         $display("%0t ns: %0d responses never arrived", $time, expected_cells.size());
         error_count += expected_cells.size();
         expected_cells.delete();
      end
   endtask

   // ------------------------------------------------------------------
   // Response side: a stall pattern that changes character every stretch,
   // and on request one long hold-off counted here in cycles.
   // ------------------------------------------------------------------
   initial begin : response_backpressure
      stall_mode_e mode;
      int          stretch;
      int          beat;
      forever begin
         mode    = stall_mode_e'($urandom_range(0, 3));
         stretch = $urandom_range(10, 150);
         for (beat = 0; beat < stretch; beat++) begin
            @(negedge clock);
            if (hold_wanted) begin
               hold_wanted = 1'b0;
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES - 1) @(negedge clock);
            end else begin
               case (mode)
                  STALL_NONE:     rsp_stall <= 1'b0;
                  STALL_RANDOM:   rsp_stall <= $urandom_range(0, 1);
                  STALL_PERIODIC: rsp_stall <= (beat % 4 == 3);
                  STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
                  default:        rsp_stall <= 1'b0;
               endcase
            end
         end
      end
   end

   task automatic check_field(string field, int unsigned want, int unsigned got,
                              denoised_cell_t exp_cell);
      if (want != got) begin
         $display("%0t ns: %s mismatch at row %0d col %0d: expected %0d, actual %0d",
                  $time, field, exp_cell.out_row, exp_cell.out_col, want, got);
         error_count++;
      end
   endtask

   // Each accepted response is matched against the oldest expectation.
   initial begin : response_monitor
      denoised_cell_t exp_cell;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_cells.size() == 0) begin
               $display("%0t ns: response with nothing expected: row %0d col %0d",
                        $time, rsp_out_row, rsp_out_col);
               error_count++;
            end else begin
               exp_cell = expected_cells.pop_front();
               responses_checked++;
               check_field("filtered_flag", exp_cell.filtered_flag, rsp_filtered_flag,
                           exp_cell);
               check_field("out_col", exp_cell.out_col, rsp_out_col, exp_cell);
               check_field("out_row", exp_cell.out_row, rsp_out_row, exp_cell);
               check_field("out_valid_frame", exp_cell.out_valid_frame,
                           rsp_out_valid_frame, exp_cell);
               check_field("frame_has_anomaly", exp_cell.frame_has_anomaly,
                           rsp_frame_has_anomaly, exp_cell);
               check_field("last_of_frame", exp_cell.last_of_frame, rsp_last_of_frame,
                           exp_cell);
            end
         end
      end
   end

   // Ends a run that has hung: far beyond the slowest correct run.
   initial begin : run_limit
      #(5_000_000);
      $display("Run limit reached with %0d responses outstanding", expected_cells.size());
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin : main_sequence
      int                    phase;
      int                    random_requests;
      int                    frame_cells;
      int                    phase_requests;
      int                    density;
      logic [CSR_DATA_W-1:0] cols_value;
      logic [CSR_DATA_W-1:0] rows_value;
      logic [CSR_DATA_W-1:0] thr_value;

      random_requests = 0;
      settings_used   = 1;

      // Synchronous reset first. The block then sweeps its plane
      // memory with req_stall high, which the handshake simply waits out.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].is_write) begin
            wait_until_drained();
            write_register(directed_rows[k].index, directed_rows[k].data);
         end else begin
            offer_cell(directed_rows[k].flag, directed_rows[k].typed, directed_rows[k].want);
         end
      end

      // Random phases. Each changes the registers while the block is idle and
      // then streams flags at a density of its own, so that some phases clear
      // most interior cells and others keep them. Phases often end mid-frame,
      // so the next geometry write lands in the middle of a frame.
      for (phase = 0; random_requests < RANDOM_REQUESTS; phase++) begin
         if (phase < EXTREME_SETTINGS) begin
            cols_value = extreme_cols[phase];
            rows_value = extreme_rows[phase];
            thr_value  = extreme_thr[phase];
         end else begin
            cols_value = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(3, 10);
            rows_value = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(3, 8);
            thr_value  = $urandom_range(0, 15);
         end

         wait_until_drained();
         // Now and then only the threshold changes, so the frame position
         // carries on across the phase boundary.
         if (phase < EXTREME_SETTINGS || $urandom_range(0, 3) != 0) begin
            write_register(CSR_GRID_COLS, cols_value);
            write_register(CSR_GRID_ROWS, rows_value);
         end
         write_register(CSR_COUNT_THRESHOLD, thr_value);
         if ($urandom_range(0, 4) == 0)
            write_register(CSR_UNUSED, $urandom_range(0, 255));
         settings_used++;

         frame_cells = grid_width() * grid_height();
         if (phase == WIDE_PHASE || phase == TALL_PHASE) begin
            phase_requests = frame_cells + frame_cells / 4;
         end else begin
            phase_requests = frame_cells * $urandom_range(1, 4) +
                             $urandom_range(0, frame_cells);
            if (phase_requests > PHASE_CAP) phase_requests = PHASE_CAP;
         end
         density      = $urandom_range(5, 60);
         gaps_enabled = ($urandom_range(0, 3) != 0);

         // On the wide grid the receiver holds off for a long stretch while
         // requests keep coming, so the queue fills and the input stalls.
         if (phase == WIDE_PHASE) begin
            gaps_enabled = 1'b0;
            hold_wanted  = 1'b1;
         end

         for (int n = 0; n < phase_requests; n++) begin
            // Halfway through the tall grid the sender pauses until every
            // response so far has come back.
            if (phase == TALL_PHASE && n == phase_requests / 2)
               wait_until_drained();
            offer_cell($urandom_range(0, 99) < density, 1'b0, '0);
            random_requests++;
         end
      end

      wait_until_drained();

      $display("Summary: %0d requests over %0d register settings, %0d responses checked.",
               request_count, settings_used, responses_checked);
      $display("Summary: %0d emitted flags kept set, %0d cleared by the neighbour count.",
               kept_set_count, cleared_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
